### hdl/tsdt_pkg.sv
package tsdt_pkg;

  // One Q16.16 style fixed-point value and a 2x3 affine matrix [a b c d e f].
  typedef logic signed [31:0] fx_t;
  typedef fx_t [5:0] mat_t;

  // Operator codes carried in the action field.
  typedef enum logic [2:0] {
    ACT_PUSH   = 3'd0,
    ACT_POP    = 3'd1,
    ACT_CONCAT = 3'd2,
    ACT_DRAW   = 3'd3,
    ACT_NAME   = 3'd4,
    ACT_NUMBER = 3'd5
  } act_t;

  // Number of operands that a concat consumes.
  localparam logic [2:0] NUM_OPS = 3'd6;

  // Input word.
  typedef struct packed {
    logic [2:0]  action;
    fx_t         value;
    logic [15:0] name_id;
  } in_t;

  // Result word.
  typedef struct packed {
    logic [15:0] draw_name;
    fx_t         m_a;
    fx_t         m_b;
    fx_t         m_c;
    fx_t         m_d;
    fx_t         m_e;
    fx_t         m_f;
    logic        overflowed;
  } out_t;

  // Shift commands that run down the row of stack cells.
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

### hdl/tsdt_stack_cell.sv
module tsdt_stack_cell
  import tsdt_pkg::*;
(
  input  logic     clk,
  input  stk_ctl_t ctl,
  input  mat_t     up_in,
  input  mat_t     down_in,
  output mat_t     data_out
);

  mat_t data_r;

  // A push takes the matrix from the neighbor above, a pop the one from below.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data_r <= up_in;
    end else if (ctl.pop) begin
      data_r <= down_in;
    end
  end

  assign data_out = data_r;

endmodule

### hdl/tsdt_concat.sv
module tsdt_concat
  import tsdt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic go,
  input  mat_t m_in,
  input  mat_t n_in,
  output logic done,
  output mat_t result
);

  localparam int PW = 64 - FRAC_BITS;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] pa_r [6];
  logic signed [PW-1:0] pb_r [6];
  fx_t                  trans_r [2];
  logic                 vld_r;

  // Clamp a wide sum to the signed 32-bit range.
  function automatic fx_t sat32(input logic signed [SW-1:0] s);
    logic [SW-32:0] hi;
    hi = s[SW-1:31];
    if ((&hi) || !(|hi)) begin
      sat32 = s[31:0];
    end else if (s[SW-1]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7fff_ffff;
    end
  endfunction

  // First stage: twelve products, each floored back to the fixed-point scale.
  for (genvar i = 0; i < 6; i++) begin : g_prod
    logic signed [63:0] pa;
    logic signed [63:0] pb;
    assign pa = $signed(m_in[i % 2]) * $signed(n_in[2 * (i / 2)]);
    assign pb = $signed(m_in[2 + (i % 2)]) * $signed(n_in[2 * (i / 2) + 1]);
    always_ff @(posedge clk) begin
      pa_r[i] <= PW'(pa >>> FRAC_BITS);
      pb_r[i] <= PW'(pb >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    trans_r[0] <= m_in[4];
    trans_r[1] <= m_in[5];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= go;
    end
  end

  // Second stage: sums with the old translation, then saturation.
  for (genvar i = 0; i < 6; i++) begin : g_sum
    logic signed [SW-1:0] s;
    if (i >= 4) begin : g_tr
      assign s = SW'(pa_r[i]) + SW'(pb_r[i]) + SW'(trans_r[i - 4]);
    end else begin : g_no_tr
      assign s = SW'(pa_r[i]) + SW'(pb_r[i]);
    end
    assign result[i] = sat32(s);
  end

  assign done = vld_r;

endmodule

### hdl/transform_stack_draw_tracker_top.sv
// Graphics-state transform tracker.
// The input channel (in_valid, in_stall, in_data) takes one tokenized operator
// or operand per word: push, pop, concat, draw, name or number. The result
// channel (out_valid, out_stall, out_data) carries one word for each draw that
// has a pending name: the name, the current matrix and the sticky overflow flag.
// A word is moved at a clock edge where valid is high and stall is low.
// Throughput: one word per cycle while in_stall is low. A concat that has six numbers
// stalls the input: its products sit in a register stage, and in_stall is high while
// the sums are written back. Push and pop move the whole row of stack cells together.
// A draw is accepted, and its result word is valid on the next cycle. While the
// receiver stalls, the result word holds; further words are still taken, and only a
// draw that would make a new result waits.
// Reset (rst_n low, synchronous) sets the identity matrix, an empty stack, no
// pending numbers or name, a clear overflow flag and no result; stack contents
// are left as they are and are only read after being written.
module transform_stack_draw_tracker_top
  import tsdt_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam fx_t FX_ONE = 32'sd1 <<< FRAC_BITS;

  mat_t        cur_r;
  logic [LW-1:0] level_r;
  mat_t        num_r;
  logic [2:0]  cnt_r;
  logic [15:0] name_r;
  logic        name_vld_r;
  logic        ovf_r;
  logic        out_valid_r;
  out_t        out_data_r;

  logic        in_fire;
  logic        is_draw;
  logic        full;
  logic        concat_go;
  logic        concat_done;
  logic        clr_pending;
  mat_t        concat_res;
  stk_ctl_t    ctl;
  mat_t        stk_q [STACK_DEPTH];

  // Handshake and decode.
  assign is_draw   = (in_data.action == ACT_DRAW);
  assign in_stall  = concat_done || (out_valid_r && out_stall && is_draw && name_vld_r);
  assign in_fire   = in_valid && !in_stall;
  assign full      = (level_r == LW'(STACK_DEPTH));
  assign ctl.push  = in_fire && (in_data.action == ACT_PUSH) && !full;
  assign ctl.pop   = in_fire && (in_data.action == ACT_POP) && (level_r != '0);
  assign concat_go = in_fire && (in_data.action == ACT_CONCAT) && (cnt_r == NUM_OPS);
  assign clr_pending = in_fire && ((in_data.action == ACT_PUSH) ||
                                   (in_data.action == ACT_POP) ||
                                   (in_data.action == ACT_CONCAT) || is_draw);

  // Row of save-stack cells; cell zero is the top of the stack.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_stk
    mat_t up_in;
    mat_t down_in;
    if (i == 0) begin : g_first
      assign up_in = cur_r;
    end else begin : g_mid
      assign up_in = stk_q[i - 1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_in = '0;
    end else begin : g_inner
      assign down_in = stk_q[i + 1];
    end
    tsdt_stack_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .up_in    (up_in),
      .down_in  (down_in),
      .data_out (stk_q[i])
    );
  end

  tsdt_concat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_concat (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (concat_go),
    .m_in   (cur_r),
    .n_in   (num_r),
    .done   (concat_done),
    .result (concat_res)
  );

  // Current matrix, stack level and overflow flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r    <= {32'sd0, 32'sd0, FX_ONE, 32'sd0, 32'sd0, FX_ONE};
      level_r  <= '0;
      ovf_r    <= 1'b0;
    end else begin
      if (concat_done) begin
        cur_r <= concat_res;
      end else if (ctl.pop) begin
        cur_r <= stk_q[0];
      end
      if (ctl.push) begin
        level_r <= level_r + 1'b1;
      end else if (ctl.pop) begin
        level_r <= level_r - 1'b1;
      end
      if (in_fire && (in_data.action == ACT_PUSH) && full) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Pending numbers: a shift line; the count tells how many are live.
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.action == ACT_NUMBER)) begin
      num_r <= {in_data.value, num_r[5:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      name_vld_r <= 1'b0;
    end else if (clr_pending) begin
      cnt_r      <= '0;
      name_vld_r <= 1'b0;
    end else if (in_fire && (in_data.action == ACT_NUMBER)) begin
      if (cnt_r != NUM_OPS) begin
        cnt_r <= cnt_r + 3'd1;
      end
    end else if (in_fire && (in_data.action == ACT_NAME)) begin
      name_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_data.action == ACT_NAME)) begin
      name_r <= in_data.name_id;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && is_draw && name_vld_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_draw && name_vld_r) begin
      out_data_r.draw_name  <= name_r;
      out_data_r.m_a        <= cur_r[0];
      out_data_r.m_b        <= cur_r[1];
      out_data_r.m_c        <= cur_r[2];
      out_data_r.m_d        <= cur_r[3];
      out_data_r.m_e        <= cur_r[4];
      out_data_r.m_f        <= cur_r[5];
      out_data_r.overflowed <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The write-back cycle of a concat always follows an accepted concat.
  a_concat_follows: assert property (@(posedge clk) disable iff (!rst_n)
    concat_done |-> $past(concat_go))
    else $error("concat write-back without an accepted concat");

  // The stack level never passes the depth.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  // The number count saturates at six.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NUM_OPS)
    else $error("number count beyond six");

  // A draw with a pending name always produces a result word.
  a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_draw && name_vld_r) |=> out_valid_r)
    else $error("draw with pending name gave no result");

endmodule

### tb/sv/transform_stack_draw_tracker_top_tb.sv
module transform_stack_draw_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tsdt_pkg::*;

  localparam int STK_DEPTH = 16;
  localparam int FRAC_BITS = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam fx_t FX_ONE = 32'sh0001_0000;
  localparam longint FX_MAX = 64'sd2147483647;
  localparam longint FX_MIN = -64'sd2147483648;

  // Action codes that the block must ignore.
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  transform_stack_draw_tracker_top #(
    .STACK_DEPTH(STK_DEPTH),
    .FRAC_BITS  (FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Predicted graphics state: current matrix [a b c d e f], save stack, operands.
  fx_t ctm [6] = '{FX_ONE, 0, 0, FX_ONE, 0, 0};
  fx_t save_stk [STK_DEPTH][6];
  int stk_lvl = 0;
  fx_t opnd [6] = '{0, 0, 0, 0, 0, 0};
  int opnd_cnt = 0;
  logic [15:0] pend_id = '0;
  bit pend_ok = 1'b0;
  bit ovf_flag = 1'b0;

  // Draw results still owed by the block, oldest first.
  out_t draw_q [$];

  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;
  bit hold_req = 1'b0;
  int n_items = 0;
  int n_results = 0;
  int fail_cnt = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Q16.16 product, shifted back toward minus infinity.
  function automatic longint fx_mul(input fx_t x, input fx_t y);
    longint xl;
    longint yl;
    xl = x;
    yl = y;
    return (xl * yl) >>> FRAC_BITS;
  endfunction

  function automatic fx_t fx_clip(input longint v);
    if (v > FX_MAX) return 32'sh7FFF_FFFF;
    if (v < FX_MIN) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void clear_operands();
    for (int i = 0; i < 6; i++) opnd[i] = '0;
    opnd_cnt = 0;
    pend_id = '0;
    pend_ok = 1'b0;
  endfunction

  // Applies one accepted word to the predicted state; returns 1 when a draw result is due.
  function automatic bit track_token(input in_t w, output out_t res);
    fx_t r [6];
    bit made;
    made = 1'b0;
    res = '0;
    case (w.action)
      ACT_PUSH: begin
        if (stk_lvl < STK_DEPTH) begin
          for (int i = 0; i < 6; i++) save_stk[stk_lvl][i] = ctm[i];
          stk_lvl++;
        end else begin
          ovf_flag = 1'b1;
        end
        clear_operands();
      end
      ACT_POP: begin
        if (stk_lvl > 0) begin
          stk_lvl--;
          for (int i = 0; i < 6; i++) ctm[i] = save_stk[stk_lvl][i];
        end
        clear_operands();
      end
      ACT_CONCAT: begin
        // New matrix is N x M in row-vector form, N built from the last six numbers.
        if (opnd_cnt >= NUM_OPS) begin
          r[0] = fx_clip(fx_mul(ctm[0], opnd[0]) + fx_mul(ctm[2], opnd[1]));
          r[1] = fx_clip(fx_mul(ctm[1], opnd[0]) + fx_mul(ctm[3], opnd[1]));
          r[2] = fx_clip(fx_mul(ctm[0], opnd[2]) + fx_mul(ctm[2], opnd[3]));
          r[3] = fx_clip(fx_mul(ctm[1], opnd[2]) + fx_mul(ctm[3], opnd[3]));
          r[4] = fx_clip(fx_mul(ctm[0], opnd[4]) + fx_mul(ctm[2], opnd[5]) + longint'(ctm[4]));
          r[5] = fx_clip(fx_mul(ctm[1], opnd[4]) + fx_mul(ctm[3], opnd[5]) + longint'(ctm[5]));
          for (int i = 0; i < 6; i++) ctm[i] = r[i];
        end
        clear_operands();
      end
      ACT_DRAW: begin
        if (pend_ok) begin
          res.draw_name = pend_id;
          res.m_a = ctm[0];
          res.m_b = ctm[1];
          res.m_c = ctm[2];
          res.m_d = ctm[3];
          res.m_e = ctm[4];
          res.m_f = ctm[5];
          res.overflowed = ovf_flag;
          made = 1'b1;
        end
        clear_operands();
      end
      ACT_NAME: begin
        pend_id = w.name_id;
        pend_ok = 1'b1;
      end
      ACT_NUMBER: begin
        for (int i = 0; i < 5; i++) opnd[i] = opnd[i + 1];
        opnd[5] = w.value;
        if (opnd_cnt < NUM_OPS) opnd_cnt++;
      end
      default: begin
      end
    endcase
    return made;
  endfunction

  // Offers one word, optionally after an idle burst, and holds it until it is taken.
  task automatic send_word(input in_t w);
    out_t res;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    if (w.action <= ACT_NUMBER) n_items++;
    if (track_token(w, res)) draw_q.insert(draw_q.size(), res);
  endtask

  task automatic send_op(input logic [2:0] a);
    in_t w;
    w.action = a;
    w.value = $urandom;
    w.name_id = 16'($urandom);
    send_word(w);
  endtask

  task automatic send_num(input fx_t v);
    in_t w;
    w.action = ACT_NUMBER;
    w.value = v;
    w.name_id = 16'($urandom);
    send_word(w);
  endtask

  task automatic send_name(input logic [15:0] id);
    in_t w;
    w.action = ACT_NAME;
    w.value = $urandom;
    w.name_id = id;
    send_word(w);
  endtask

  // Stops offering words and waits until every owed result has come out.
  task automatic wait_all_drawn();
    in_valid <= 1'b0;
    @(posedge clk);
    while (hold_req || draw_q.size() != 0) @(posedge clk);
  endtask

  // Operand mix: small scales, unit values, raw 32-bit patterns and the range limits.
  function automatic fx_t rand_fx();
    fx_t v;
    case ($urandom_range(0, 5))
      0: v = $signed($urandom_range(0, 262144)) - 131072;
      1: v = $urandom_range(0, 1) ? FX_ONE : -FX_ONE;
      2: v = $urandom;
      3: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh7FFF_FFFF;
          1: v = 32'sh8000_0000;
          2: v = '0;
          default: v = -1;
        endcase
      end
      default: v = $signed($urandom_range(0, 65536)) - 32768;
    endcase
    return v;
  endfunction

  // One random scene: mostly push / numbers / cm / name / Do / pop, sometimes noise.
  task automatic send_scene(input bit guard);
    int kind;
    int k;
    bit pushed;
    logic [2:0] a;
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      pushed = ($urandom_range(0, 3) != 0) && !(guard && stk_lvl >= STK_DEPTH);
      if (pushed) send_op(ACT_PUSH);
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : NUM_OPS;
      repeat (k) send_num(rand_fx());
      // A name given before the concat is dropped by it.
      if ($urandom_range(0, 5) == 0) send_name(16'($urandom));
      send_op(ACT_CONCAT);
      repeat ($urandom_range(1, 2)) begin
        send_name(16'($urandom));
        if ($urandom_range(0, 3) == 0) send_num(rand_fx());
        send_op(ACT_DRAW);
      end
      if (pushed ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 7) == 0))
        send_op(ACT_POP);
    end else if (kind < 9) begin
      repeat ($urandom_range(1, 6)) begin
        a = 3'($urandom_range(0, 7));
        if (guard && a == ACT_PUSH && stk_lvl >= STK_DEPTH) a = ACT_POP;
        send_op(a);
      end
    end else begin
      send_name(16'($urandom));
      send_op(ACT_DRAW);
      send_op(ACT_DRAW);
    end
  endtask

  // Draw with and without a pending name, name replacement, ignored codes.
  task automatic test_draw_basics();
    send_op(ACT_DRAW);
    send_name(16'h0000);
    send_name(16'hFFFF);
    send_op(ACT_DRAW);
    send_op(ACT_DRAW);
    send_op(ACT_SPARE6);
    send_op(ACT_SPARE7);
    wait_all_drawn();
  endtask

  // A concat with fewer than six numbers keeps the matrix and drops the name.
  task automatic test_concat_rules();
    repeat (5) send_num(32'sh0002_0000);
    send_name(16'h1234);
    send_op(ACT_CONCAT);
    send_op(ACT_DRAW);
    wait_all_drawn();
  endtask

  // Pop on an empty stack, more than six numbers, extreme operands, restore on pop.
  task automatic test_stack_basics();
    send_op(ACT_POP);
    send_op(ACT_PUSH);
    send_num(FX_ONE);
    send_num(32'sh7FFF_FFFF);
    send_num(32'sh8000_0000);
    send_num(32'sh8000_0000);
    send_num(32'sh7FFF_FFFF);
    send_num(32'sh7FFF_FFFF);
    send_num(32'sh8000_0000);
    send_op(ACT_CONCAT);
    send_name(16'h8001);
    send_op(ACT_DRAW);
    send_op(ACT_POP);
    send_name(16'h7FFE);
    send_op(ACT_DRAW);
    wait_all_drawn();
  endtask

  task automatic test_random_scenes(input int upto, input bit guard, input bit idle);
    gaps_on = idle;
    stalls_on = idle;
    while (n_items < upto) begin
      if (idle) gaps_on = ($urandom_range(0, 3) != 0);
      send_scene(guard);
    end
    wait_all_drawn();
  endtask

  // The receiver holds off for a long stretch while draws keep being offered.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_req = 1'b1;
    repeat (12) begin
      send_name(16'($urandom));
      send_op(ACT_DRAW);
    end
    wait_all_drawn();
  endtask

  // Fill the save stack, drop one push, draw with the sticky flag, unwind.
  task automatic test_stack_overflow();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    repeat (STK_DEPTH - stk_lvl + 1) send_op(ACT_PUSH);
    send_name(16'hA5A5);
    send_op(ACT_DRAW);
    while (stk_lvl > 0) send_op(ACT_POP);
    send_op(ACT_POP);
    wait_all_drawn();
  endtask

  // Receiver pacing: random stall bursts, plus the long hold when requested.
  initial begin : rx_pacing
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, actual %h", field, want, got);
      fail_cnt++;
    end
  endfunction

  // Each accepted result word is matched against the oldest owed draw.
  initial begin : result_check
    out_t exp_w;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        n_results++;
        if (draw_q.size() == 0) begin
          $error("result word with no draw owed: draw_name %h", out_data.draw_name);
          fail_cnt++;
        end else begin
          exp_w = draw_q.pop_front();
          check_field("draw_name", 32'(exp_w.draw_name), 32'(out_data.draw_name));
          check_field("m_a", exp_w.m_a, out_data.m_a);
          check_field("m_b", exp_w.m_b, out_data.m_b);
          check_field("m_c", exp_w.m_c, out_data.m_c);
          check_field("m_d", exp_w.m_d, out_data.m_d);
          check_field("m_e", exp_w.m_e, out_data.m_e);
          check_field("m_f", exp_w.m_f, out_data.m_f);
          check_field("overflowed", 32'(exp_w.overflowed), 32'(out_data.overflowed));
        end
      end
    end
  end

  // Ends the run if no word moves on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("[transform_stack_draw_tracker_top] ERROR");
    $finish;
  end

  initial begin : run
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_draw_basics();
    test_concat_rules();
    test_stack_basics();
    test_random_scenes(900, 1'b1, 1'b1);
    test_backpressure();
    test_stack_overflow();
    test_random_scenes(1350, 1'b0, 1'b0);
    wait_all_drawn();
    repeat (8) @(posedge clk);
    $display("Sent %0d tokens and checked %0d draw words, including a %0d-cycle output hold",
             n_items, n_results, HOLD_CYCLES);
    $display("and a dropped push on a full save stack.");
    if (fail_cnt == 0) begin
      $display("[transform_stack_draw_tracker_top] OK");
    end else begin
      $display("[transform_stack_draw_tracker_top] ERROR");
    end
    $finish;
  end

endmodule
